// ----- design/q24_alu_pkg.sv -----
package q24_alu_pkg;

  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned DataW = 32;
  // Quotient bits resolved per divider stage
  localparam int unsigned DivBits = 4;

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MUL    = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_CMP    = 4'd4,
    CMD_MIN    = 4'd5,
    CMD_MAX    = 4'd6,
    CMD_INC    = 4'd7,
    CMD_DEC    = 4'd8,
    CMD_TO_INT = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]        command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic [1:0]         status;
  } out_item_t;

  // Per-stage side information that rides next to the divider
  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] simple;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               neg;
    logic               b_zero;
    logic [63:0]        prod_mag;
  } side_t;

endpackage

// ----- design/q24_alu_div.sv -----
// Pipelined restoring divider: BitsPerStage quotient bits per stage.
// Computes q = floor(num / den) with the remainder; num is NumW bits, den DenW bits.
module q24_alu_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 32,
  parameter int unsigned BitsPerStage = q24_alu_pkg::DivBits
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [NumW-1:0] quo,
  output logic [DenW:0]   rem,
  output logic [DenW-1:0] den_out
);
  localparam int unsigned Stages = (NumW + BitsPerStage - 1) / BitsPerStage;
  localparam int unsigned TotW = Stages * BitsPerStage;

  logic [TotW-1:0] q_r   [Stages+1];
  logic [DenW:0]   rem_r [Stages+1];
  logic [DenW-1:0] den_r [Stages+1];

  always_comb begin
    q_r[0]   = TotW'(num);
    rem_r[0] = '0;
    den_r[0] = den;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [TotW-1:0] q_nxt;
    logic [DenW:0]   rem_nxt;
    logic [TotW-1:0] q_st_r;
    logic [DenW:0]   rem_st_r;
    logic [DenW-1:0] den_st_r;

    always_comb begin
      logic [DenW+1:0] t;
      q_nxt   = q_r[s];
      rem_nxt = rem_r[s];
      for (int k = 0; k < int'(BitsPerStage); k++) begin
        t = {rem_nxt, q_nxt[TotW-1]};
        q_nxt = {q_nxt[TotW-2:0], 1'b0};
        if (t >= {2'b00, den_r[s]}) begin
          t = t - {2'b00, den_r[s]};
          q_nxt[0] = 1'b1;
        end
        rem_nxt = t[DenW:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_st_r   <= q_nxt;
        rem_st_r <= rem_nxt;
        den_st_r <= den_r[s];
      end
    end

    always_comb begin
      q_r[s+1]   = q_st_r;
      rem_r[s+1] = rem_st_r;
      den_r[s+1] = den_st_r;
    end
  end

  assign quo     = q_r[Stages][NumW-1:0];
  assign rem     = rem_r[Stages];
  assign den_out = den_r[Stages];
endmodule

// ----- design/fixed_point_q24_8_alu.sv -----
// Channel | Direction | Signals                   | Payload
// in      | input     | in_valid / in_ready       | q24_alu_pkg::in_item_t
// out     | output    | out_valid / out_ready     | q24_alu_pkg::out_item_t
//
// One transaction per cycle while out is not stalled; a transaction is offered
// on out after it has passed the decode register, the divider stages at four
// quotient bits each with the multiply beside the first, and the finish
// register. The divider depth sets the latency.
// Reset (rst_n low, synchronous) clears every valid bit and holds in_ready low;
// payload is not reset. A stall on out freezes the whole pipeline; in_ready
// drops only while the last stage holds a transaction that out has not taken.
module fixed_point_q24_8_alu #(
  parameter int unsigned FRAC_BITS = q24_alu_pkg::FracBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  q24_alu_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output q24_alu_pkg::out_item_t out_data
);
  localparam int unsigned NumW = 32 + FRAC_BITS;
  localparam int unsigned DivStages =
    (NumW + q24_alu_pkg::DivBits - 1) / q24_alu_pkg::DivBits;
  localparam int unsigned Lat = DivStages + 2;

  // Global advance: the pipeline moves when the last stage is empty or drained
  logic adv;
  logic [Lat-1:0] vld_r;
  assign adv      = !vld_r[Lat-1] || out_ready;
  assign in_ready = adv && rst_n;

  // Stage 0: decode, compare, simple ops, divider operands
  q24_alu_pkg::side_t s0_nxt, s0_r;
  logic [NumW-1:0] num_nxt;
  logic [31:0]     den_nxt;
  logic signed [31:0] a, b;

  always_comb begin
    a = in_data.operand_a;
    b = in_data.operand_b;
    s0_nxt = '0;
    s0_nxt.command    = in_data.command;
    s0_nxt.is_less    = a < b;
    s0_nxt.is_equal   = a == b;
    s0_nxt.is_greater = a > b;
    s0_nxt.b_zero     = b == 0;
    case (q24_alu_pkg::cmd_t'(in_data.command))
      q24_alu_pkg::CMD_ADD:    s0_nxt.simple = a + b;
      q24_alu_pkg::CMD_SUB:    s0_nxt.simple = a - b;
      q24_alu_pkg::CMD_MIN:    s0_nxt.simple = (a < b) ? a : b;
      q24_alu_pkg::CMD_MAX:    s0_nxt.simple = (a > b) ? a : b;
      q24_alu_pkg::CMD_INC:    s0_nxt.simple = a + 32'sd1;
      q24_alu_pkg::CMD_DEC:    s0_nxt.simple = a - 32'sd1;
      q24_alu_pkg::CMD_TO_INT: s0_nxt.simple = a >>> FRAC_BITS;
      default:                 s0_nxt.simple = '0;
    endcase
    s0_nxt.neg = a[31] ^ b[31];
    // Magnitudes; drop sign for the multiply too
    num_nxt = NumW'({1'b0, (a[31] ? 32'(-a) : 32'(a))}) << FRAC_BITS;
    den_nxt = b[31] ? 32'(-b) : 32'(b);
  end

  logic [31:0] ma_r, mb_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
      ma_r <= a[31] ? 32'(-a) : 32'(a);
      mb_r <= den_nxt;
    end
  end

  // Stage 1: 32x32 unsigned magnitude multiply, then carry along
  q24_alu_pkg::side_t s1_nxt;
  q24_alu_pkg::side_t side_r [1:Lat-2];
  always_comb begin
    s1_nxt          = s0_r;
    s1_nxt.prod_mag = {32'b0, ma_r} * {32'b0, mb_r};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= s1_nxt;
      for (int i = 2; i <= int'(Lat) - 2; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Divider operands register beside stage 0; the quotient lines up with side_r[Lat-2]
  logic [NumW-1:0] num_r;
  logic [31:0]     den_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end
  logic [NumW-1:0] quo;
  logic [32:0]     rem;
  logic [31:0]     den_o;
  q24_alu_div #(.NumW(NumW), .DenW(32), .BitsPerStage(q24_alu_pkg::DivBits)) u_div (
    .clk, .adv, .num(num_r), .den(den_r),
    .quo, .rem, .den_out(den_o)
  );

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  // Finish stage: rounding, sign, saturation, select
  q24_alu_pkg::side_t sl;
  q24_alu_pkg::out_item_t o_nxt, o_r;
  logic [64:0] pm;
  logic [NumW:0] dq;
  logic [64:0] mag;
  logic        neg;
  always_comb begin
    sl  = side_r[Lat-2];
    pm  = 65'(sl.prod_mag) + 65'(65'd1 << (FRAC_BITS - 1));
    // Round half up on remainder: 2*rem >= den
    dq  = (NumW+1)'(quo) + (NumW+1)'({rem, 1'b0} >= {2'b00, den_o});
    mag = '0;
    neg = sl.neg;
    o_nxt = '0;
    o_nxt.is_less    = sl.is_less;
    o_nxt.is_equal   = sl.is_equal;
    o_nxt.is_greater = sl.is_greater;
    o_nxt.status     = q24_alu_pkg::ST_OK;
    o_nxt.result     = sl.simple;
    case (q24_alu_pkg::cmd_t'(sl.command))
      q24_alu_pkg::CMD_MUL, q24_alu_pkg::CMD_DIV: begin
        if (sl.command == q24_alu_pkg::CMD_MUL) mag = pm >> FRAC_BITS;
        else mag = 65'(dq);
        if (sl.command == q24_alu_pkg::CMD_DIV && sl.b_zero) begin
          o_nxt.result = '0;
          o_nxt.status = q24_alu_pkg::ST_DIVZERO;
        end else if (neg && mag > 65'h8000_0000) begin
          o_nxt.result = 32'sh8000_0000;
          o_nxt.status = q24_alu_pkg::ST_SAT;
        end else if (!neg && mag > 65'h7FFF_FFFF) begin
          o_nxt.result = 32'sh7FFF_FFFF;
          o_nxt.status = q24_alu_pkg::ST_SAT;
        end else begin
          o_nxt.result = neg ? 32'(-mag[31:0]) : mag[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) o_r <= o_nxt;
  end

  assign out_valid = vld_r[Lat-1];
  assign out_data  = o_r;

  // Output held while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  // Flags are mutually exclusive
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.is_less, out_data.is_equal, out_data.is_greater}))
    else $error("compare flags not one-hot");
  // Divide-by-zero yields zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == q24_alu_pkg::ST_DIVZERO |-> out_data.result == 0)
    else $error("divzero result nonzero");
endmodule
